/* rtl/rdq_pkg.sv */
package rdq_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic exec;
    logic load_out;
  } rdq_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } rdq_sts_t;

endpackage

/* rtl/rdq_in_if.sv */
interface rdq_in_if;
  logic                            valid;
  logic                            ready;
  logic [rdq_pkg::CMD_W-1:0]       command;
  logic signed [rdq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

/* rtl/rdq_out_if.sv */
interface rdq_out_if;
  logic                              valid;
  logic                              ready;
  logic [rdq_pkg::STAT_W-1:0]        status;
  logic signed [rdq_pkg::DATA_W-1:0] popped_value;

  modport source (output valid, output status, output popped_value, input ready);
  modport sink (input valid, input status, input popped_value, output ready);
endinterface

/* rtl/rdq_ctrl.sv */
module rdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdq_pkg::rdq_sts_t sts,
  output rdq_pkg::rdq_ctl_t ctl
);
  import rdq_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t state;

  // no beat is taken while reset is held
  assign in_ready     = (state == S_IDLE) && !rst;
  assign ctl.exec     = in_valid && in_ready;
  assign ctl.load_out = (state == S_RESULT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_RESULT;
        end
        S_RESULT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_exec_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> (state == S_RESULT))
    else $error("accepted beat did not move to result state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.exec && ctl.load_out))
    else $error("accept and result load in the same cycle");

  a_load_frees: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |=> in_ready)
    else $error("controller not idle after result load");

endmodule

/* rtl/rdq_datapath.sv */
module rdq_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rdq_pkg::CMD_W-1:0]          item_command,
  input  logic signed [rdq_pkg::DATA_W-1:0]  item_value,
  input  rdq_pkg::rdq_ctl_t                  ctl,
  output rdq_pkg::rdq_sts_t                  sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rdq_pkg::STAT_W-1:0]         out_status,
  output logic signed [rdq_pkg::DATA_W-1:0]  out_value
);
  import rdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              reversed;
  logic              reversed_next;

  logic [STAT_W-1:0] pend_status;
  logic [STAT_W-1:0] pend_status_next;

  logic              is_push;
  logic              is_pop;
  logic              at_front;
  logic              full;
  logic              empty;
  logic [ADDR_W-1:0] back_slot;
  logic [ADDR_W-1:0] tail_slot;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  // ring wraps by truncation, the depth is a power of two
  assign back_slot = head + count[ADDR_W-1:0];
  assign tail_slot = back_slot - ADDR_W'(1);

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    at_front = 1'b0;
    unique case (item_command)
      CMD_PUSH_FRONT: begin
        is_push  = 1'b1;
        at_front = !reversed;
      end
      CMD_PUSH_BACK: begin
        is_push  = 1'b1;
        at_front = reversed;
      end
      CMD_POP_FRONT: begin
        is_pop   = 1'b1;
        at_front = !reversed;
      end
      CMD_POP_BACK: begin
        is_pop   = 1'b1;
        at_front = reversed;
      end
      default: ;
    endcase
  end

  always_comb begin
    head_next        = head;
    count_next       = count;
    reversed_next    = reversed;
    pend_status_next = pend_status;
    wr_en            = 1'b0;
    wr_addr          = back_slot;
    rd_en            = 1'b0;
    rd_addr          = at_front ? head : tail_slot;
    if (ctl.exec) begin
      pend_status_next = ST_DONE;
      if (is_push) begin
        if (full) begin
          pend_status_next = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
          if (at_front) begin
            head_next = head - ADDR_W'(1);
            wr_addr   = head - ADDR_W'(1);
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          pend_status_next = ST_EMPTY;
        end else begin
          rd_en            = 1'b1;
          pend_status_next = ST_VALID;
          count_next       = count - CNT_W'(1);
          if (at_front) head_next = head + ADDR_W'(1);
        end
      end else begin
        // reverse and the unused codes flip direction
        reversed_next = !reversed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= item_value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
    pend_status <= pend_status_next;
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.load_out) begin
      out_status <= pend_status;
      out_value  <= (pend_status == ST_VALID) ? rd_data : '0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    full |-> !(wr_en && ctl.exec && count_next != count))
    else $error("write into a full ring");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> sts.out_free)
    else $error("result loaded over an untaken beat");

  a_reverse_toggles: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && !is_push && !is_pop) |=> (reversed != $past(reversed)))
    else $error("reverse did not flip direction");

endmodule

/* rtl/reversible_deque.sv */
// Double-ended queue of up to 1024 signed 32-bit values in a ring buffer
// (single-port-write, registered-read RAM). Each command beat on items gives
// exactly one result beat on results: status plus popped value (zero unless
// status is popped-value-valid). Reverse, and the unused command codes 5 to 7,
// swap the meaning of front and back for all later commands. A push into a
// full queue is dropped and reports full; a pop from an empty queue reports
// empty. A command is handled in order: the accept cycle updates the pointers
// and issues the RAM access, then the result state moves the result into the
// output register once that register is free, after which the next command
// is taken. A result waiting on results holds off the next command only
// until the output register frees. The RAM needs no clearing after reset.
module reversible_deque (
  input  logic clk,
  input  logic rst,
  rdq_in_if.sink    items,
  rdq_out_if.source results
);
  import rdq_pkg::*;

  rdq_ctl_t ctl;
  rdq_sts_t sts;
  logic     in_ready;

  assign items.ready = in_ready;

  rdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rdq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item_command (items.command),
    .item_value   (items.push_value),
    .ctl          (ctl),
    .sts          (sts),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_status   (results.status),
    .out_value    (results.popped_value)
  );

endmodule
